[rtl/b64sd_pkg.sv]
// Shared types, constants and symbol lookup for the base64 stream decoder.
package b64sd_pkg;

	localparam int SEXTET_W  = 6;
	localparam int BUF_W     = 3 * SEXTET_W;
	localparam int MAX_BURST = 3;
	localparam logic [7:0] HIGH_PAIR = 8'hC0;

	// One decoded byte with its two flags
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       msg_end;
	} b64sd_entry_t;

	// Up to three bytes produced by one request, entry 0 first
	typedef struct packed {
		b64sd_entry_t [MAX_BURST-1:0] ent;
		logic [1:0]                   n;
	} b64sd_burst_t;

	// Symbol lookup: bit 6 set for an alphabet character, low six bits its value
	function automatic logic [SEXTET_W:0] sym_lookup(input logic [7:0] c);
		logic [SEXTET_W:0] r;
		r = '0;
		case (c) inside
			[8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
			[8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h61 + 8'd26)};
			[8'h30:8'h39]: r = {1'b1, 6'(c - 8'h30 + 8'd52)};
			8'h2B:         r = {1'b1, 6'd62};
			8'h2F:         r = {1'b1, 6'd63};
			default:       r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/base64_stream_decoder.sv]
// Top level of the base64 stream decoder.
//
//  channel  dir  tdata          tuser      tlast
//  s_*      in   in_char[7:0]   -          is_last
//  m_*      out  out_byte[7:0]  run_last   message_end
//
// One character per cycle is accepted while s_tready is high: it is registered,
// decoded combinationally against the pending symbols and its zero to three bytes
// enter an output queue of DEPTH entries, which releases one byte per cycle while m_tready is high.
// s_tready drops while a registered character waits for three free queue slots.
// Reset clears the pending symbols, the input register and the queue.
module base64_stream_decoder #(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] run_last
	output logic       m_tlast
);
	import b64sd_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic         space;
	logic         advance;
	b64sd_burst_t burst;
	b64sd_entry_t out_ent;

	assign advance  = valid_s1 && space;
	assign s_tready = !valid_s1 || space;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	b64sd_unpack u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.in_char (char_s1),
		.is_last (last_s1),
		.burst   (burst)
	);

	b64sd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ent   (out_ent)
	);

	assign m_tdata = out_ent.data;
	assign m_tuser = out_ent.run_last;
	assign m_tlast = out_ent.msg_end;

endmodule

[rtl/b64sd_unpack.sv]
// Symbol gathering and byte generation for one character per cycle while en is high.
module b64sd_unpack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            in_char,
	input  logic                  is_last,
	output b64sd_pkg::b64sd_burst_t burst
);
	import b64sd_pkg::*;

	logic [BUF_W-1:0]    buf_q, buf_nxt;
	logic [1:0]          cnt_q, cnt_nxt;
	logic [SEXTET_W:0]   sym;
	logic [SEXTET_W-1:0] v;
	logic [7:0]          bytes [MAX_BURST];
	logic [1:0]          n;

	assign sym = sym_lookup(in_char);
	assign v   = sym[SEXTET_W-1:0];

	// Next state and produced bytes
	always_comb begin
		buf_nxt  = buf_q;
		cnt_nxt  = cnt_q;
		n        = 2'd0;
		bytes[0] = '0;
		bytes[1] = '0;
		bytes[2] = '0;
		if (sym[SEXTET_W]) begin
			if (cnt_q == 2'd3) begin
				// fourth symbol completes the group
				bytes[0] = buf_q[17:10];
				bytes[1] = buf_q[9:2];
				bytes[2] = ((8'(buf_q[1:0]) << 6) & HIGH_PAIR) | {2'b00, v};
				n        = 2'd3;
				buf_nxt  = '0;
				cnt_nxt  = 2'd0;
			end else begin
				buf_nxt = {buf_q[BUF_W-SEXTET_W-1:0], v};
				cnt_nxt = cnt_q + 2'd1;
			end
		end
		if (is_last) begin
			// flush a partial group; n is zero whenever a partial group is left
			if (cnt_nxt == 2'd2) begin
				bytes[0] = buf_nxt[11:4];
				n        = 2'd1;
			end else if (cnt_nxt == 2'd3) begin
				bytes[0] = buf_nxt[17:10];
				bytes[1] = buf_nxt[9:2];
				n        = 2'd2;
			end
			buf_nxt = '0;
			cnt_nxt = 2'd0;
		end
	end

	// Pack the burst with per-byte flags
	always_comb begin
		for (int k = 0; k < MAX_BURST; k++) begin
			burst.ent[k].data     = bytes[k];
			burst.ent[k].run_last = (2'(k + 1) == n);
			burst.ent[k].msg_end  = (2'(k + 1) == n) && is_last;
		end
		burst.n = en ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= 2'd0;
		end else if (en) begin
			buf_q <= buf_nxt;
			cnt_q <= cnt_nxt;
		end
	end

endmodule

[rtl/b64sd_queue.sv]
// Output queue: takes up to three entries per cycle, releases one while out_ready is high.
module b64sd_queue #(
	parameter int DEPTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64sd_pkg::b64sd_burst_t burst,
	output logic                    space,
	output logic                    out_valid,
	input  logic                    out_ready,
	output b64sd_pkg::b64sd_entry_t out_ent
);
	import b64sd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64sd_entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr [MAX_BURST];
	logic             pop;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_ent   = mem_q[head_q];
	assign space     = (count_q <= CNT_W'(DEPTH - MAX_BURST));

	// Write addresses for the burst
	always_comb begin
		wr_ptr[0] = tail_q;
		wr_ptr[1] = wrap_inc(tail_q);
		wr_ptr[2] = wrap_inc(wr_ptr[1]);
	end

	// Storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_BURST; k++) begin
			if (2'(k) < burst.n)
				mem_q[wr_ptr[k]] <= burst.ent[k];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= wrap_inc(head_q);
			case (burst.n)
				2'd1:    tail_q <= wr_ptr[1];
				2'd2:    tail_q <= wr_ptr[2];
				2'd3:    tail_q <= wrap_inc(wr_ptr[2]);
				default: tail_q <= tail_q;
			endcase
			count_q <= count_q + CNT_W'(burst.n) - CNT_W'(pop);
		end
	end

endmodule

[rtl/b64sd_checker.sv]
// Port-level checks for the base64 stream decoder, bound to the top level.
module b64sd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// The end of a message is always the last byte of its request
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("message end without run end");

	// Leaving reset: queue empty and input open
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid && s_tready)
		else $error("not empty and ready after reset");

	// A stalled output byte stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped under stall");

	// A stalled output byte keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output payload changed under stall");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/tb.sv]
// Self-checking testbench for the base64 stream decoder.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64sd_pkg::*;

	localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

	// One character request waiting to be offered
	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} char_req_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] in_char
	logic       s_tlast  = 1'b0;    // is_last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tuser;            // [0] run_last
	logic       m_tlast;            // message_end

	char_req_t    char_queue[$];
	b64sd_entry_t byte_fifo[$];

	// Predictor state: pending symbols, newest in the low bits
	logic [17:0] pend_bits = '0;
	logic [1:0]  pend_cnt  = '0;

	int  src_idle_pct  = 0;
	int  snk_stall_pct = 0;
	bit  hold_go       = 1'b0;
	bit  hold_on       = 1'b0;
	int  n_fail        = 0;

	base64_stream_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Bit 6 flags an alphabet character, low six bits hold its value
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 6'(c - 8'h41)};          // A-Z
		if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h61 + 8'd26)};  // a-z
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};  // 0-9
		if (c == 8'h2B) return {1'b1, 6'd62};                                 // +
		if (c == 8'h2F) return {1'b1, 6'd63};                                 // /
		return 7'd0;
	endfunction

	function automatic logic [7:0] sextet_char(input int v);
		if (v < 26) return 8'(8'h41 + v);
		if (v < 52) return 8'(8'h61 + v - 26);
		if (v < 62) return 8'(8'h30 + v - 52);
		if (v == 62) return 8'h2B;
		return 8'h2F;
	endfunction

	// Decode one accepted character and queue the bytes it yields
	task automatic decode_char(input logic [7:0] ch, input logic fin);
		logic [6:0]   sx;
		logic [7:0]   outb[3];
		int           n;
		b64sd_entry_t e;
		n  = 0;
		sx = sextet_of(ch);
		if (sx[6]) begin
			if (pend_cnt == 2'd3) begin
				outb[0]   = pend_bits[17:10];
				outb[1]   = pend_bits[9:2];
				outb[2]   = {pend_bits[1:0], sx[5:0]};
				n         = 3;
				pend_bits = '0;
				pend_cnt  = '0;
			end else begin
				pend_bits = {pend_bits[11:0], sx[5:0]};
				pend_cnt  = pend_cnt + 2'd1;
			end
		end
		// end of message: flush a partial group, drop a lone symbol
		if (fin) begin
			if (pend_cnt == 2'd2) begin
				outb[n] = pend_bits[11:4];
				n++;
			end else if (pend_cnt == 2'd3) begin
				outb[n]     = pend_bits[17:10];
				outb[n + 1] = pend_bits[9:2];
				n += 2;
			end
			pend_bits = '0;
			pend_cnt  = '0;
		end
		for (int k = 0; k < n; k++) begin
			e.data     = outb[k];
			e.run_last = (k == n - 1);
			e.msg_end  = (k == n - 1) && fin;
			byte_fifo.push_back(e);
		end
	endtask

	// Source side: offer queued characters, predict on every accepted one
	always @(posedge clk) begin : src_drive
		char_req_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				decode_char(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (char_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					r = char_queue.pop_front();
					s_tdata  <= r.ch;
					s_tlast  <= r.fin;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: check each accepted byte against the oldest prediction
	always @(posedge clk) begin : snk_check
		b64sd_entry_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (byte_fifo.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected byte: expected none, actual %02h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = byte_fifo.pop_front();
					if (want.data !== m_tdata || want.run_last !== m_tuser ||
							want.msg_end !== m_tlast) begin
						n_fail++;
						$display("%0t: byte mismatch: expected %02h/%b/%b, actual %02h/%b/%b",
							$time, want.data, want.run_last, want.msg_end,
							m_tdata, m_tuser, m_tlast);
					end
				end
			end
			m_tready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Long sink hold-off so the output queue fills and backs up the input
	initial begin : long_hold
		wait (hold_go);
		@(negedge clk);
		hold_on = 1'b1;
		repeat (80) @(posedge clk);
		@(negedge clk);
		hold_on = 1'b0;
	end

	initial begin : watchdog
		#2_000_000;
		$display("** base64_stream_decoder: FAILED **");
		$finish;
	end

	task automatic push_char(input logic [7:0] ch, input logic fin);
		char_req_t r;
		r.ch  = ch;
		r.fin = fin;
		char_queue.push_back(r);
	endtask

	task automatic push_text(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], fin && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] skip_char();
		logic [7:0] c;
		logic [6:0] sx;
		do begin
			c  = 8'($urandom_range(255));
			sx = sextet_of(c);
		end while (sx[6]);
		return c;
	endfunction

	// Message of n_sym symbols, sometimes with stray bytes and padding
	task automatic queue_message(input int n_sym);
		bit pad_end;
		pad_end = (n_sym == 0) || ($urandom_range(2) == 0);
		for (int i = 0; i < n_sym; i++) begin
			if ($urandom_range(5) == 0)
				push_char(skip_char(), 1'b0);
			push_char(sextet_char($urandom_range(63)), !pad_end && (i == n_sym - 1));
		end
		if (pad_end) begin
			if (n_sym % 4 == 2)
				push_char(PAD_CHAR, 1'b0);
			push_char(PAD_CHAR, 1'b1);
		end
	endtask

	// Mostly messages with random content, some raw random bytes
	task automatic queue_phase(input int sym_goal);
		int got;
		int n;
		got = 0;
		while (got < sym_goal) begin
			if ($urandom_range(4) == 0) begin
				push_char(8'($urandom_range(255)), $urandom_range(7) == 0);
			end else begin
				n = $urandom_range(13);
				queue_message(n);
				got += n;
			end
		end
	endtask

	task automatic drain_source();
		while (char_queue.size() != 0 || s_tvalid) @(negedge clk);
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: full group with end flag, three/two/one-symbol flushes,
		// empty end, alphabet edges and neighbors of several ranges
		push_text("TW@Fu", 1'b1);
		push_text("TWE=", 1'b1);
		push_text("T[Q", 1'b1);
		push_text("A", 1'b1);
		push_char(8'hFF, 1'b1);
		push_text("+/9zaZ0", 1'b0);
		push_char(8'h00, 1'b1);
		push_text("`{,/", 1'b1);

		// Phase without idling, with the long sink hold-off
		queue_phase(15);
		hold_go = 1'b1;
		drain_source();

		src_idle_pct = 64;
		queue_phase(15);
		drain_source();

		src_idle_pct  = 0;
		snk_stall_pct = 64;
		queue_phase(15);
		drain_source();

		src_idle_pct  = 36;
		snk_stall_pct = 36;
		queue_phase(15);
		drain_source();

		src_idle_pct  = 0;
		snk_stall_pct = 0;
		while (byte_fifo.size() != 0) @(negedge clk);
		repeat (20) @(posedge clk);

		if (n_fail == 0)
			$display("** base64_stream_decoder: PASSED **");
		else
			$display("** base64_stream_decoder: FAILED **");
		$finish;
	end

endmodule
